// ===== rtl/replica_ising_metropolis_step_defines.svh =====
// Assertion macros shared by the lattice flip engine RTL.
`ifndef REPLICA_ISING_METROPOLIS_STEP_DEFINES_SVH
`define REPLICA_ISING_METROPOLIS_STEP_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define RIMS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition in one cycle that forces a consequence in the next one.
`define RIMS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rims_pkg.sv =====
// Shared constants, codes and types of the lattice flip engine.
package rims_pkg;

  localparam int ROWS        = 32;
  localparam int COLS        = 32;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int COL_W       = $clog2(COLS);
  localparam int THR_COUNT   = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DRAW_W      = 32;
  localparam int CHANGE_W    = 4;
  localparam int TALLY_W     = 13;
  localparam int TALLY_LIMIT = 3072;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_TRIAL = 1'b1;

  // Register indexes: thresholds sit at indexes zero through five.
  localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd6;

  // Row reads issued when an item is accepted.
  typedef struct packed {
    logic             en;
    logic [ROW_W-1:0] dn;
    logic [ROW_W-1:0] mid;
    logic [ROW_W-1:0] up;
  } spin_rd_req_t;

  // One full row write.
  typedef struct packed {
    logic             we;
    logic [ROW_W-1:0] row;
    logic [COLS-1:0]  data;
  } spin_wr_req_t;

  // The three rows around the chosen site.
  typedef struct packed {
    logic [COLS-1:0] dn;
    logic [COLS-1:0] mid;
    logic [COLS-1:0] up;
  } spin_rows_t;

endpackage

// ===== rtl/rims_spin_mem.sv =====
// Row-wide spin storage of one replica with reset-to-plus-one and write forwarding.
module rims_spin_mem
  import rims_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  spin_rd_req_t rd_i,
  input  spin_wr_req_t wr_i,
  output spin_rows_t   rows_o
);

  // Copy a serves the two neighbor rows, copy b the center row.
  logic [COLS-1:0] mem_a [ROWS];
  logic [COLS-1:0] mem_b [ROWS];

  logic [ROWS-1:0] row_vld_q;
  logic [COLS-1:0] dn_q, mid_q, up_q;
  logic [COLS-1:0] fwd_data_q;
  logic            vld_dn_q, vld_mid_q, vld_up_q;
  logic            hit_dn_q, hit_mid_q, hit_up_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_a[wr_i.row] <= wr_i.data;
      mem_b[wr_i.row] <= wr_i.data;
    end
    if (rd_i.en) begin
      dn_q       <= mem_a[rd_i.dn];
      up_q       <= mem_a[rd_i.up];
      mid_q      <= mem_b[rd_i.mid];
      fwd_data_q <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      vld_dn_q  <= 1'b0;
      vld_mid_q <= 1'b0;
      vld_up_q  <= 1'b0;
      hit_dn_q  <= 1'b0;
      hit_mid_q <= 1'b0;
      hit_up_q  <= 1'b0;
    end else begin
      if (wr_i.we) begin
        row_vld_q[wr_i.row] <= 1'b1;
      end
      if (rd_i.en) begin
        vld_dn_q  <= row_vld_q[rd_i.dn];
        vld_mid_q <= row_vld_q[rd_i.mid];
        vld_up_q  <= row_vld_q[rd_i.up];
        // A write at the same edge as the read is missed by the array read.
        hit_dn_q  <= wr_i.we && (wr_i.row == rd_i.dn);
        hit_mid_q <= wr_i.we && (wr_i.row == rd_i.mid);
        hit_up_q  <= wr_i.we && (wr_i.row == rd_i.up);
      end
    end
  end

  // Rows never written still hold their reset pattern of all plus one.
  assign rows_o.dn  = hit_dn_q  ? fwd_data_q : (vld_dn_q  ? dn_q  : '1);
  assign rows_o.mid = hit_mid_q ? fwd_data_q : (vld_mid_q ? mid_q : '1);
  assign rows_o.up  = hit_up_q  ? fwd_data_q : (vld_up_q  ? up_q  : '1);

endmodule

// ===== rtl/rims_flip_part.sv =====
// Energy change of flipping one site in one replica, from its three rows.
module rims_flip_part
  import rims_pkg::*;
(
  input  spin_rows_t                  rows_i,
  input  logic [COL_W-1:0]            col_i,
  output logic signed [CHANGE_W-1:0]  part_o
);

  logic [COL_W-1:0]          lf, rt;
  logic [2:0]                ones;
  logic signed [CHANGE_W-1:0] half;

  always_comb begin
    rt = (col_i == COL_W'(COLS - 1)) ? '0 : col_i + 1'b1;
    lf = (col_i == '0) ? COL_W'(COLS - 1) : col_i - 1'b1;
    ones = 3'(rows_i.up[col_i]) + 3'(rows_i.dn[col_i]) + 3'(rows_i.up[lf])
         + 3'(rows_i.dn[rt]) + 3'(rows_i.mid[rt]) + 3'(rows_i.mid[lf]);
    half = $signed({1'b0, ones}) - 4'sd3;
    part_o = rows_i.mid[col_i] ? -half : half;
  end

endmodule

// ===== rtl/replica_ising_metropolis_step.sv =====
// Top level of the two-replica triangular-lattice Metropolis flip engine.
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i/in_stall_o   command, replica, row, col, spin, draw
//   out       source     out_valid_o/out_stall_i accepted, energy_change, energy_tally
//   cfg       sink       cfg_we_i                cfg_idx_i, cfg_data_i
//
// A beat is accepted in every cycle that the input is not stalled.
// The first stage reads the three neighbor rows of each replica from row-wide
// storage, the second evaluates, writes the changed rows back and loads the result.
// Reset marks every row unwritten, so all spins read as plus one at once.
// A stalled result holds the evaluation stage, which then stalls the input.
module replica_ising_metropolis_step
  import rims_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic                       replica_i,
  input  logic [4:0]                 row_i,
  input  logic [4:0]                 col_i,
  input  logic                       spin_value_i,
  input  logic [DRAW_W-1:0]          random_draw_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       accepted_o,
  output logic signed [CHANGE_W-1:0] energy_change_o,
  output logic signed [TALLY_W-1:0]  energy_tally_o,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

`include "replica_ising_metropolis_step_defines.svh"

  logic [DRAW_W-1:0] thr_q [THR_COUNT];
  logic              coupling_neg_q;

  logic              s1_valid_q, s1_valid_d;
  logic              s1_cmd_q, s1_rep_q, s1_spin_q, s1_inrange_q;
  logic [ROW_W-1:0]  s1_row_q;
  logic [COL_W-1:0]  s1_col_q;
  logic [DRAW_W-1:0] s1_draw_q;

  logic                       out_valid_q, out_valid_d;
  logic                       out_acc_q;
  logic signed [CHANGE_W-1:0] out_change_q;
  logic signed [TALLY_W-1:0]  out_tally_q;
  logic signed [TALLY_W-1:0]  tally_q, tally_d;

  logic             accept_in, s1_adv, commit;
  logic [ROW_W-1:0] in_row;
  spin_rd_req_t     rd_req;
  spin_wr_req_t     wr_first, wr_second;
  spin_rows_t       rows_first, rows_second;

  logic signed [CHANGE_W-1:0] part_first, part_second, part_own, part_other;
  logic signed [CHANGE_W-1:0] change, k;
  logic signed [TALLY_W:0]    tally_sum;
  logic [DRAW_W-1:0]          thr_sel;
  logic                       tied, trial, load, flip_acc;
  logic [COLS-1:0]            new_first, new_second;

  // Handshake.
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign accept_in  = in_valid_i && !in_stall_o;
  assign commit     = s1_valid_q && s1_adv;

  // Row reads with periodic wrap.
  assign in_row = row_i[ROW_W-1:0];
  always_comb begin
    rd_req.en  = accept_in;
    rd_req.mid = in_row;
    rd_req.up  = (in_row == ROW_W'(ROWS - 1)) ? '0 : in_row + 1'b1;
    rd_req.dn  = (in_row == '0) ? ROW_W'(ROWS - 1) : in_row - 1'b1;
  end

  rims_spin_mem u_mem_first (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .wr_i   (wr_first),
    .rows_o (rows_first)
  );

  rims_spin_mem u_mem_second (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd_req),
    .wr_i   (wr_second),
    .rows_o (rows_second)
  );

  rims_flip_part u_part_first (
    .rows_i (rows_first),
    .col_i  (s1_col_q),
    .part_o (part_first)
  );

  rims_flip_part u_part_second (
    .rows_i (rows_second),
    .col_i  (s1_col_q),
    .part_o (part_second)
  );

  // Evaluation stage.
  always_comb begin
    tied       = int'(s1_row_q) < ROWS / 2;
    trial      = s1_inrange_q && (s1_cmd_q == CMD_TRIAL);
    load       = s1_inrange_q && (s1_cmd_q == CMD_LOAD);
    part_own   = s1_rep_q ? part_second : part_first;
    part_other = s1_rep_q ? part_first : part_second;
    change     = trial ? (part_own + (tied ? part_other : '0)) : '0;
    k          = coupling_neg_q ? -change : change;

    unique case (k)
      4'sd1:   thr_sel = thr_q[0];
      4'sd2:   thr_sel = thr_q[1];
      4'sd3:   thr_sel = thr_q[2];
      4'sd4:   thr_sel = thr_q[3];
      4'sd5:   thr_sel = thr_q[4];
      4'sd6:   thr_sel = thr_q[5];
      default: thr_sel = '0;
    endcase

    flip_acc = trial && ((k <= 4'sd0) || (s1_draw_q <= thr_sel));

    // A load writes the addressed replica only; a flip also inverts the tied partner.
    new_first  = rows_first.mid;
    new_second = rows_second.mid;
    new_first[s1_col_q]  = load ? s1_spin_q : ~rows_first.mid[s1_col_q];
    new_second[s1_col_q] = load ? s1_spin_q : ~rows_second.mid[s1_col_q];

    wr_first.we    = commit && ((load && !s1_rep_q) || (flip_acc && (!s1_rep_q || tied)));
    wr_first.row   = s1_row_q;
    wr_first.data  = new_first;
    wr_second.we   = commit && ((load && s1_rep_q) || (flip_acc && (s1_rep_q || tied)));
    wr_second.row  = s1_row_q;
    wr_second.data = new_second;

    tally_sum = {tally_q[TALLY_W-1], tally_q} + (TALLY_W + 1)'(change);
    tally_d   = tally_q;
    if (commit && flip_acc) begin
      priority if (tally_sum > $signed((TALLY_W + 1)'(TALLY_LIMIT))) begin
        tally_d = TALLY_W'(TALLY_LIMIT);
      end else if (tally_sum < -$signed((TALLY_W + 1)'(TALLY_LIMIT))) begin
        tally_d = -$signed(TALLY_W'(TALLY_LIMIT));
      end else begin
        tally_d = tally_sum[TALLY_W-1:0];
      end
    end

    s1_valid_d  = accept_in ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
    out_valid_d = commit ? 1'b1 : (out_stall_i ? out_valid_q : 1'b0);
  end

  // Control state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      tally_q        <= '0;
      coupling_neg_q <= 1'b0;
      for (int i = 0; i < THR_COUNT; i++) begin
        thr_q[i] <= '0;
      end
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      tally_q     <= tally_d;
      if (cfg_we_i) begin
        for (int i = 0; i < THR_COUNT; i++) begin
          if (cfg_idx_i == CFG_IDX_W'(i)) begin
            thr_q[i] <= cfg_data_i;
          end
        end
        if (cfg_idx_i == CFG_COUPLING) begin
          coupling_neg_q <= cfg_data_i[0];
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      s1_cmd_q     <= command_i;
      s1_rep_q     <= replica_i;
      s1_row_q     <= in_row;
      s1_col_q     <= col_i[COL_W-1:0];
      s1_spin_q    <= spin_value_i;
      s1_draw_q    <= random_draw_i;
      s1_inrange_q <= (int'(row_i) < ROWS) && (int'(col_i) < COLS);
    end
    if (commit) begin
      out_acc_q    <= flip_acc;
      out_change_q <= change;
      out_tally_q  <= tally_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign accepted_o      = out_acc_q;
  assign energy_change_o = out_change_q;
  assign energy_tally_o  = out_tally_q;

  `RIMS_ASSERT(a_tally_bounded,
    (tally_q <= $signed(TALLY_W'(TALLY_LIMIT))) && (tally_q >= -$signed(TALLY_W'(TALLY_LIMIT))),
    "energy tally left its saturation bounds")
  `RIMS_ASSERT(a_stall_needs_item, !in_stall_o || (s1_valid_q && out_valid_q),
    "input stalled without a held item")
  `RIMS_ASSERT_NEXT(a_tally_only_on_flip, !(commit && flip_acc), $stable(tally_q),
    "tally moved without an accepted flip")
  `RIMS_ASSERT(a_change_range,
    !commit || ((change <= 4'sd6) && (change >= -4'sd6)),
    "energy change outside six coupling units")

endmodule

// ===== test/tb_replica_ising_metropolis_step.sv =====
// Self-checking testbench for the two-replica triangular-lattice flip engine.
module tb_replica_ising_metropolis_step;
  timeunit 1ns;
  timeprecision 1ps;
  import rims_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESH_BASE = 3'd0;
  localparam int RANDOM_PER_PHASE = 120;
  localparam int SETTLE_CYCLES    = 6;
  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int PUSH_ROW         = 3;
  localparam int PUSH_COL         = 10;
  localparam int PUSH_STEPS       = 4;

  typedef enum int {LEVELS_MAX, LEVELS_ZERO, LEVELS_LADDER, LEVELS_RANDOM} level_mode_e;

  // Mirror of both spin grids, the registers and the tally, plus the queue of
  // results predicted for accepted beats.
  class flip_ledger;
    typedef struct {
      logic                       accepted;
      logic signed [CHANGE_W-1:0] change;
      logic signed [TALLY_W-1:0]  tally;
    } outcome_t;

    bit                spins [2][ROWS][COLS];
    logic [DRAW_W-1:0] thresh [THR_COUNT];
    bit                coupling_neg;
    int                tally;
    int                tally_hi;
    int                tally_lo;
    int                flips;
    int                beats_in;
    int                beats_out;
    outcome_t          pending_q[$];

    function new();
      foreach (spins[i, j, k]) spins[i][j][k] = 1'b1;
      foreach (thresh[i]) thresh[i] = '0;
      coupling_neg = 1'b0;
      tally = 0;
      tally_hi = 0;
      tally_lo = 0;
      flips = 0;
      beats_in = 0;
      beats_out = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      if (idx < THR_COUNT) thresh[idx] = data;
      else if (idx == CFG_COUPLING) coupling_neg = data[0];
    endfunction

    // Energy change in units of J that one replica contributes to a flip.
    function int flip_part(input int rep, input int r, input int c);
      int up;
      int dn;
      int rt;
      int lf;
      int ones;
      up = (r + 1) % ROWS;
      dn = (r + ROWS - 1) % ROWS;
      rt = (c + 1) % COLS;
      lf = (c + COLS - 1) % COLS;
      ones = int'(spins[rep][up][c]) + int'(spins[rep][dn][c]) + int'(spins[rep][up][lf])
           + int'(spins[rep][dn][rt]) + int'(spins[rep][r][rt]) + int'(spins[rep][r][lf]);
      return spins[rep][r][c] ? 3 - ones : ones - 3;
    endfunction

    function void note_input(input logic cmd, input logic rep, input logic [4:0] row,
                             input logic [4:0] col, input logic spin,
                             input logic [DRAW_W-1:0] draw);
      outcome_t want;
      int change;
      int k;
      int r;
      int c;
      bit tied;
      bit acc;
      change = 0;
      acc = 1'b0;
      r = row;
      c = col;
      beats_in++;
      if (r < ROWS && c < COLS) begin
        tied = (r < ROWS / 2);
        if (cmd == CMD_LOAD) begin
          spins[rep][r][c] = spin;
        end else begin
          change = flip_part(rep, r, c);
          if (tied) change += flip_part(!rep, r, c);
          k = coupling_neg ? -change : change;
          acc = (k <= 0) || (draw <= thresh[k - 1]);
          if (acc) begin
            spins[rep][r][c] = !spins[rep][r][c];
            if (tied) spins[!rep][r][c] = !spins[!rep][r][c];
            tally += change;
            if (tally > TALLY_LIMIT) tally = TALLY_LIMIT;
            if (tally < -TALLY_LIMIT) tally = -TALLY_LIMIT;
            flips++;
          end
        end
      end
      if (tally > tally_hi) tally_hi = tally;
      if (tally < tally_lo) tally_lo = tally;
      want.accepted = acc;
      want.change = CHANGE_W'(change);
      want.tally = TALLY_W'(tally);
      pending_q.push_back(want);
    endfunction

    function bit check_result(input logic acc, input logic signed [CHANGE_W-1:0] chg,
                              input logic signed [TALLY_W-1:0] tly, output string why);
      outcome_t want;
      why = "";
      beats_out++;
      if (pending_q.size() == 0) begin
        why = $sformatf("result beat %0d arrived with no prediction pending", beats_out);
        return 1'b0;
      end
      want = pending_q.pop_front();
      if (acc !== want.accepted || chg !== want.change || tly !== want.tally) begin
        why = $sformatf("result beat %0d: accepted %0b/%0b change %0d/%0d tally %0d/%0d (got/want)",
                        beats_out, acc, want.accepted, chg, want.change, tly, want.tally);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic                       command_i = CMD_LOAD;
  logic                       replica_i = 1'b0;
  logic [4:0]                 row_i = '0;
  logic [4:0]                 col_i = '0;
  logic                       spin_value_i = 1'b0;
  logic [DRAW_W-1:0]          random_draw_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic                       accepted_o;
  logic signed [CHANGE_W-1:0] energy_change_o;
  logic signed [TALLY_W-1:0]  energy_tally_o;
  logic                       cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0]      cfg_data_i = '0;

  flip_ledger ledger = new();
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         quiet_cycles = 0;
  string      rx_why;

  replica_ising_metropolis_step DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .replica_i      (replica_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .spin_value_i   (spin_value_i),
    .random_draw_i  (random_draw_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .energy_change_o(energy_change_o),
    .energy_tally_o (energy_tally_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string why);
    $display("MISMATCH @%0t: %s", $time, why);
    fail_count++;
  endtask

  // Result side: random stall, and every result beat taken is checked.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (!ledger.check_result(accepted_o, energy_change_o, energy_tally_o, rx_why))
          report_mismatch(rx_why);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
      $display("tb_replica_ising_metropolis_step NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_beat(input logic cmd, input logic rep, input logic [4:0] row,
                           input logic [4:0] col, input logic spin,
                           input logic [DRAW_W-1:0] draw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    replica_i     <= rep;
    row_i         <= row;
    col_i         <= col;
    spin_value_i  <= spin;
    random_draw_i <= draw;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_input(cmd, rep, row, col, spin, draw);
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline drain.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_regs(input level_mode_e mode, input bit neg);
    logic [CFG_DATA_W-1:0] value;
    for (int i = 0; i < THR_COUNT; i++) begin
      case (mode)
        LEVELS_MAX:    value = '1;
        LEVELS_ZERO:   value = '0;
        LEVELS_LADDER: value = (i + 1) * 32'h2AAA_AAAA;
        default: begin
          case ($urandom_range(5))
            0:       value = '0;
            1:       value = '1;
            default: value = $urandom();
          endcase
        end
      endcase
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_THRESH_BASE + CFG_IDX_W'(i);
      cfg_data_i <= value;
      ledger.set_reg(CFG_THRESH_BASE + CFG_IDX_W'(i), value);
      @(posedge clk_i);
    end
    // Upper bits of the coupling register carry noise; only bit zero counts.
    value = $urandom();
    value[0] = neg;
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_COUPLING;
    cfg_data_i <= value;
    ledger.set_reg(CFG_COUPLING, value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Draws cluster on the current acceptance levels so both sides of each compare occur.
  function automatic logic [DRAW_W-1:0] pick_draw();
    logic [DRAW_W-1:0] level;
    level = ledger.thresh[$urandom_range(THR_COUNT - 1)];
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return level + $urandom_range(2) - 1;
      default: return $urandom();
    endcase
  endfunction

  task automatic random_beat();
    logic [4:0] row;
    logic [4:0] col;
    case ($urandom_range(3))
      0: begin  // around the boundary of the tied half
        row = 5'(14 + $urandom_range(3));
        col = 5'($urandom());
      end
      1: begin  // tight cluster across the wrapping corner
        row = 5'(30 + $urandom_range(3));
        col = 5'(30 + $urandom_range(3));
      end
      default: begin
        row = 5'($urandom());
        col = 5'($urandom());
      end
    endcase
    send_beat(($urandom_range(99) < 35) ? CMD_LOAD : CMD_TRIAL, 1'($urandom()), row, col,
              1'($urandom()), pick_draw());
  endtask

  // Repeatedly flip one tied site whose fourteen spins are arranged for a change
  // of six, restoring it by loads, to move the tally in the largest steps.
  task automatic push_tally(input bit rise, input int steps);
    int   dr [6] = '{1, -1, 1, -1, 0, 0};
    int   dc [6] = '{0, 0, -1, 1, 1, -1};
    logic site_spin;
    site_spin = 1'($urandom());
    for (int rep = 0; rep < 2; rep++) begin
      for (int n = 0; n < 6; n++)
        send_beat(CMD_LOAD, 1'(rep), 5'(PUSH_ROW + dr[n]), 5'(PUSH_COL + dc[n]),
                  rise ? !site_spin : site_spin, $urandom());
      send_beat(CMD_LOAD, 1'(rep), 5'(PUSH_ROW), 5'(PUSH_COL), site_spin, $urandom());
    end
    for (int s = 0; s < steps; s++) begin
      send_beat(CMD_TRIAL, 1'($urandom()), 5'(PUSH_ROW), 5'(PUSH_COL), 1'($urandom()),
                pick_draw());
      send_beat(CMD_LOAD, 1'b0, 5'(PUSH_ROW), 5'(PUSH_COL), site_spin, $urandom());
      send_beat(CMD_LOAD, 1'b1, 5'(PUSH_ROW), 5'(PUSH_COL), site_spin, $urandom());
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset lattice with evenly spaced levels.
    program_regs(LEVELS_LADDER, 1'b0);
    send_beat(CMD_TRIAL, 1'b0, 5'd0, 5'd0, 1'b0, '0);
    send_beat(CMD_TRIAL, 1'b1, 5'd0, 5'd0, 1'b1, '1);
    send_beat(CMD_TRIAL, 1'b0, 5'd31, 5'd31, 1'b0, '1);
    send_beat(CMD_TRIAL, 1'b0, 5'd31, 5'd31, 1'b0, ledger.thresh[2] + 1);
    send_beat(CMD_TRIAL, 1'b0, 5'd31, 5'd31, 1'b1, ledger.thresh[2]);
    send_beat(CMD_LOAD, 1'b1, 5'd5, 5'd7, 1'b0, '1);
    send_beat(CMD_TRIAL, 1'b0, 5'd5, 5'd7, 1'b0, $urandom());
    send_beat(CMD_LOAD, 1'b0, 5'd16, 5'd31, 1'b0, '0);
    send_beat(CMD_LOAD, 1'b0, 5'd16, 5'd0, 1'b0, '1);
    send_beat(CMD_TRIAL, 1'b0, 5'd16, 5'd30, 1'b1, '1);
    send_beat(CMD_TRIAL, 1'b1, 5'd15, 5'd31, 1'b0, '1);
    send_beat(CMD_TRIAL, 1'b0, 5'd16, 5'd31, 1'b0, '0);
    send_beat(CMD_LOAD, 1'b0, 5'd0, 5'd5, 1'b1, '0);
    send_beat(CMD_TRIAL, 1'b1, 5'd31, 5'd0, 1'b0, '1);
    // Back-to-back trials on one site and on its neighbor.
    send_beat(CMD_TRIAL, 1'b0, 5'd1, 5'd1, 1'b0, '0);
    send_beat(CMD_TRIAL, 1'b0, 5'd1, 5'd1, 1'b0, '0);
    send_beat(CMD_TRIAL, 1'b1, 5'd1, 5'd1, 1'b0, '0);
    send_beat(CMD_TRIAL, 1'b0, 5'd0, 5'd1, 1'b0, '0);
    send_beat(CMD_LOAD, 1'b1, 5'd0, 5'd1, 1'b1, '1);
    send_beat(CMD_TRIAL, 1'b1, 5'd0, 5'd1, 1'b1, '1);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          program_regs(LEVELS_MAX, 1'b0);
        end
        1: begin
          send_idle_pct = 73;
          stall_pct = 0;
          program_regs(LEVELS_RANDOM, 1'b1);
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 73;
          program_regs(LEVELS_ZERO, 1'b1);
        end
        default: begin
          send_idle_pct = 24;
          stall_pct = 24;
          program_regs(LEVELS_RANDOM, 1'b0);
        end
      endcase
      repeat (RANDOM_PER_PHASE) random_beat();
      settle();
      if (phase == 1) begin
        send_idle_pct = 24;
        stall_pct = 24;
        program_regs(LEVELS_RANDOM, 1'b1);
        push_tally(1'b1, PUSH_STEPS);
        settle();
        program_regs(LEVELS_RANDOM, 1'b0);
        push_tally(1'b0, PUSH_STEPS);
        settle();
      end
    end

    $display("Checked %0d result beats against %0d input beats, %0d flips accepted.",
             ledger.beats_out, ledger.beats_in, ledger.flips);
    $display("Tally swept %0d..%0d under both coupling signs and four idle/stall mixes.",
             ledger.tally_lo, ledger.tally_hi);
    if (fail_count == 0 && ledger.pending() == 0) begin
      $display("tb_replica_ising_metropolis_step OK");
    end else begin
      $display("tb_replica_ising_metropolis_step NOT OK");
    end
    $finish;
  end

endmodule
